>>> rtl/core/pcbg_pkg.sv
package pcbg_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF     = 17;

    localparam int IN_TDATA_BITS  = 8;
    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int INC_BITS       = 32;
    localparam int VOLUME_BITS    = 5;
    localparam int SCALE_BITS     = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_INC  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INC_STEP   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHIRP_LEN  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_LEN = 3'd4;

    localparam int VOLUME_SCALE = 1000;
    localparam int VOLUME_RESET = 10;
    localparam int CHIRP_RESET  = 4800;
    localparam int PERIOD_RESET = 48000;

    localparam int FRAC_BITS  = 16;
    localparam int XF_BITS    = 17;
    localparam int INNER_BITS = 16;
    localparam int Y_BITS     = 18;
    localparam int SIN_A      = 102944;
    localparam int SIN_B      = 42048;
    localparam int SIN_C      = 4640;
    localparam int SINE_STAGES = 6;

    typedef struct packed {
        logic chirp;
        logic last;
    } item_flags_t;

endpackage

>>> rtl/core/pcbg_cfg.sv
module pcbg_cfg #(
    parameter int COUNT_BITS = pcbg_pkg::COUNT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [pcbg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pcbg_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    output logic [pcbg_pkg::SCALE_BITS-1:0]       scale,
    output logic [pcbg_pkg::INC_BITS-1:0]         start_inc,
    output logic signed [pcbg_pkg::INC_BITS-1:0]  inc_step,
    output logic [COUNT_BITS-1:0]                 chirp_count,
    output logic [COUNT_BITS-1:0]                 period_len
);
    import pcbg_pkg::*;

    logic [SCALE_BITS-1:0]      scale_reg;
    logic [SCALE_BITS-1:0]      scale_next;
    logic [INC_BITS-1:0]        start_inc_reg;
    logic signed [INC_BITS-1:0] inc_step_reg;
    logic [COUNT_BITS-1:0]      chirp_count_reg;
    logic [COUNT_BITS-1:0]      period_len_reg;

    // volume times 1000 kept ready for the output multiplier
    assign scale_next = SCALE_BITS'(cfg_wdata[VOLUME_BITS-1:0] * VOLUME_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg       <= SCALE_BITS'(VOLUME_RESET * VOLUME_SCALE);
            start_inc_reg   <= '0;
            inc_step_reg    <= '0;
            chirp_count_reg <= COUNT_BITS'(CHIRP_RESET);
            period_len_reg  <= COUNT_BITS'(PERIOD_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VOLUME:     scale_reg       <= scale_next;
                REG_START_INC:  start_inc_reg   <= cfg_wdata[INC_BITS-1:0];
                REG_INC_STEP:   inc_step_reg    <= cfg_wdata[INC_BITS-1:0];
                REG_CHIRP_LEN:  chirp_count_reg <= COUNT_BITS'(cfg_wdata);
                REG_PERIOD_LEN: period_len_reg  <= COUNT_BITS'(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    assign scale       = scale_reg;
    assign start_inc   = start_inc_reg;
    assign inc_step    = inc_step_reg;
    assign chirp_count = chirp_count_reg;
    assign period_len  = period_len_reg;

endmodule

>>> rtl/core/pcbg_ctrl.sv
module pcbg_ctrl #(
    parameter int PHASE_BITS = pcbg_pkg::PHASE_BITS_DEF,
    parameter int COUNT_BITS = pcbg_pkg::COUNT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  in_keep_running,
    input  logic [pcbg_pkg::INC_BITS-1:0]         start_inc,
    input  logic signed [pcbg_pkg::INC_BITS-1:0]  inc_step,
    input  logic [COUNT_BITS-1:0]                 chirp_count,
    input  logic [COUNT_BITS-1:0]                 period_len,
    output logic                                  out_valid,
    output logic [PHASE_BITS-1:0]                 out_phase,
    output pcbg_pkg::item_flags_t                 out_flags
);
    import pcbg_pkg::*;

    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] inc_reg;
    logic [PHASE_BITS-1:0] inc_next;
    logic [COUNT_BITS-1:0] index_reg;
    logic [COUNT_BITS-1:0] index_next;
    logic                  active_reg;
    logic                  active_next;

    logic                  accept;
    logic                  start;
    logic                  produce;
    logic [COUNT_BITS-1:0] period;
    logic [COUNT_BITS-1:0] idx;
    logic [COUNT_BITS:0]   idx_inc;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] inc;
    logic                  chirp;
    logic                  last;

    assign accept  = in_valid && in_ready;
    assign start   = !active_reg && in_keep_running;
    assign produce = active_reg || in_keep_running;

    // a zero period length behaves as one
    assign period  = (period_len == '0) ? COUNT_BITS'(1) : period_len;
    assign idx     = start ? '0 : index_reg;
    assign phase   = start ? '0 : acc_reg;
    assign inc     = start ? PHASE_BITS'(start_inc) : inc_reg;
    assign chirp   = (idx < chirp_count) && (idx < period);
    assign idx_inc = {1'b0, idx} + 1'b1;
    assign last    = idx_inc >= {1'b0, period};

    always_comb begin
        acc_next    = acc_reg;
        inc_next    = inc_reg;
        index_next  = index_reg;
        active_next = active_reg;
        if (accept && produce) begin
            acc_next    = chirp ? phase + inc : phase;
            inc_next    = chirp ? inc + PHASE_BITS'(inc_step) : inc;
            active_next = !last;
            index_next  = last ? '0 : idx_inc[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            inc_reg    <= '0;
            index_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            acc_reg    <= acc_next;
            inc_reg    <= inc_next;
            index_reg  <= index_next;
            active_reg <= active_next;
        end
    end

    assign out_valid       = accept && produce;
    assign out_phase       = phase;
    assign out_flags.chirp = chirp;
    assign out_flags.last  = last;

`ifndef ASSERT_OFF
    a_idle_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> index_reg == '0)
        else $error("sample index not cleared outside a period");
`endif

endmodule

>>> rtl/core/pcbg_sine.sv
module pcbg_sine #(
    parameter int PHASE_BITS     = pcbg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = pcbg_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [PHASE_BITS-1:0]              in_phase,
    input  pcbg_pkg::item_flags_t              in_flags,
    input  logic [pcbg_pkg::SCALE_BITS-1:0]    scale,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pcbg_pkg::SAMPLE_BITS-1:0]   out_sample,
    output pcbg_pkg::item_flags_t              out_flags
);
    import pcbg_pkg::*;

    localparam int QBITS     = SINE_ADDR_BITS - 2;
    localparam int SQ_BITS   = 2 * XF_BITS;
    localparam int CP_BITS   = XF_BITS + 13;
    localparam int MP_BITS   = XF_BITS + INNER_BITS;
    localparam int MAG_BITS  = Y_BITS + SCALE_BITS + 1;
    localparam int MAG_LIMIT = 31500;

    logic [SINE_STAGES-1:0] valid_reg;
    logic [SINE_STAGES-1:0] valid_next;
    logic [SINE_STAGES:0]   ready;

    logic [PHASE_BITS-1:0]  s1_phase_reg;
    item_flags_t            s1_flags_reg;

    logic [XF_BITS-1:0]     s2_xf_reg;
    logic [XF_BITS-1:0]     s2_x2_reg;
    logic                   s2_neg_reg;
    item_flags_t            s2_flags_reg;

    logic [XF_BITS-1:0]     s3_xf_reg;
    logic [XF_BITS-1:0]     s3_x2_reg;
    logic [INNER_BITS-1:0]  s3_inner_reg;
    logic                   s3_neg_reg;
    item_flags_t            s3_flags_reg;

    logic [XF_BITS-1:0]     s4_xf_reg;
    logic [XF_BITS-1:0]     s4_mid_reg;
    logic                   s4_neg_reg;
    item_flags_t            s4_flags_reg;

    logic [Y_BITS-1:0]      s5_y_reg;
    logic                   s5_neg_reg;
    item_flags_t            s5_flags_reg;

    logic [SAMPLE_BITS-1:0] s6_sample_reg;
    item_flags_t            s6_flags_reg;

    logic [SINE_ADDR_BITS-1:0] addr;
    logic [1:0]                quad;
    logic [QBITS-1:0]          w;
    logic [QBITS:0]            x;
    logic [XF_BITS-1:0]        s2_xf_next;
    logic [SQ_BITS-1:0]        sq;
    logic [XF_BITS-1:0]        s2_x2_next;
    logic [CP_BITS-1:0]        cp;
    logic [INNER_BITS-1:0]     s3_inner_next;
    logic [MP_BITS-1:0]        mp;
    logic [XF_BITS-1:0]        s4_mid_next;
    logic [SQ_BITS-1:0]        yp;
    logic [Y_BITS-1:0]         s5_y_next;
    logic [MAG_BITS-1:0]       mag_prod;
    logic [SAMPLE_BITS-1:0]    mag;
    logic [SAMPLE_BITS-1:0]    s6_sample_next;

    // stall chain: a stage takes new data when empty or when it hands on
    always_comb begin
        ready[SINE_STAGES] = out_ready;
        for (int k = SINE_STAGES - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_next = {valid_reg[SINE_STAGES-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < SINE_STAGES; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // quadrant fold and first square
    assign addr       = s1_phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign quad       = addr[SINE_ADDR_BITS-1 -: 2];
    assign w          = addr[QBITS-1:0];
    assign x          = quad[0] ? ((QBITS+1)'(1 << QBITS) - {1'b0, w}) : {1'b0, w};
    assign s2_xf_next = XF_BITS'(x) << (FRAC_BITS - QBITS);
    assign sq         = SQ_BITS'(s2_xf_next) * SQ_BITS'(s2_xf_next);
    assign s2_x2_next = sq[FRAC_BITS +: XF_BITS];

    // polynomial terms
    assign cp            = CP_BITS'(s2_x2_reg) * CP_BITS'(SIN_C);
    assign s3_inner_next = INNER_BITS'(SIN_B) - INNER_BITS'(cp[CP_BITS-1:FRAC_BITS]);

    assign mp          = MP_BITS'(s3_x2_reg) * MP_BITS'(s3_inner_reg);
    assign s4_mid_next = XF_BITS'(SIN_A) - mp[FRAC_BITS +: XF_BITS];

    assign yp        = SQ_BITS'(s4_xf_reg) * SQ_BITS'(s4_mid_reg);
    assign s5_y_next = yp[FRAC_BITS +: Y_BITS];

    // amplitude scaling with rounding, sign from the quadrant
    assign mag_prod = MAG_BITS'(s5_y_reg) * MAG_BITS'(scale)
                    + MAG_BITS'(1 << (FRAC_BITS - 1));
    assign mag      = mag_prod[FRAC_BITS +: SAMPLE_BITS];

    always_comb begin
        if (!s5_flags_reg.chirp) begin
            s6_sample_next = '0;
        end else if (s5_neg_reg) begin
            s6_sample_next = SAMPLE_BITS'(0) - mag;
        end else begin
            s6_sample_next = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            s1_phase_reg <= in_phase;
            s1_flags_reg <= in_flags;
        end
        if (ready[1]) begin
            s2_xf_reg    <= s2_xf_next;
            s2_x2_reg    <= s2_x2_next;
            s2_neg_reg   <= quad[1];
            s2_flags_reg <= s1_flags_reg;
        end
        if (ready[2]) begin
            s3_xf_reg    <= s2_xf_reg;
            s3_x2_reg    <= s2_x2_reg;
            s3_inner_reg <= s3_inner_next;
            s3_neg_reg   <= s2_neg_reg;
            s3_flags_reg <= s2_flags_reg;
        end
        if (ready[3]) begin
            s4_xf_reg    <= s3_xf_reg;
            s4_mid_reg   <= s4_mid_next;
            s4_neg_reg   <= s3_neg_reg;
            s4_flags_reg <= s3_flags_reg;
        end
        if (ready[4]) begin
            s5_y_reg     <= s5_y_next;
            s5_neg_reg   <= s4_neg_reg;
            s5_flags_reg <= s4_flags_reg;
        end
        if (ready[5]) begin
            s6_sample_reg <= s6_sample_next;
            s6_flags_reg  <= s5_flags_reg;
        end
    end

    assign in_ready   = ready[0];
    assign out_valid  = valid_reg[SINE_STAGES-1];
    assign out_sample = s6_sample_reg;
    assign out_flags  = s6_flags_reg;

`ifndef ASSERT_OFF
    a_silence_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_flags.chirp |-> out_sample == '0)
        else $error("non-zero sample outside the chirp");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_flags.chirp |->
            ($signed(out_sample) <= MAG_LIMIT) && ($signed(out_sample) >= -MAG_LIMIT))
        else $error("chirp sample beyond peak amplitude");

    a_square_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] |-> s2_x2_reg <= XF_BITS'(1 << FRAC_BITS))
        else $error("folded phase square out of range");
`endif

endmodule

>>> rtl/core/periodic_chirp_burst_generator_top.sv
// channel   dir  signals                      contents
// s_        in   tvalid tready tdata[7:0]     tdata[0] keep_running
// m_        out  tvalid tready tdata tuser    tdata sample, tuser in_chirp, tlast period_end
// cfg_      in   wr_en index wdata            volume, start_increment, increment_step,
//                                             chirp_samples, period_samples
//
// one tick transfer per cycle while s_tready is high; a sample passes every sine stage register before it leaves
// the period sequencer updates phase and counters in the cycle of the tick
// the sine polynomial and amplitude scaling run over five registered multiply stages
// a tick outside a period with keep_running low gives no sample
// reset clears sequencer state, stage valids and loads register defaults
// s_tready falls only when all six stages hold samples and m_tready is low
module periodic_chirp_burst_generator_top #(
    parameter int PHASE_BITS     = pcbg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = pcbg_pkg::SINE_ADDR_BITS_DEF,
    parameter int COUNT_BITS     = pcbg_pkg::COUNT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pcbg_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // keep_running
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pcbg_pkg::SAMPLE_BITS-1:0]     m_tdata,   // sample
    output logic [0:0]                           m_tuser,   // in_chirp
    output logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [pcbg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pcbg_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import pcbg_pkg::*;

    logic [SCALE_BITS-1:0]      scale;
    logic [INC_BITS-1:0]        start_inc;
    logic signed [INC_BITS-1:0] inc_step;
    logic [COUNT_BITS-1:0]      chirp_count;
    logic [COUNT_BITS-1:0]      period_len;

    logic                       item_valid;
    logic [PHASE_BITS-1:0]      item_phase;
    item_flags_t                item_flags;
    item_flags_t                out_flags;

    pcbg_cfg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .scale       (scale),
        .start_inc   (start_inc),
        .inc_step    (inc_step),
        .chirp_count (chirp_count),
        .period_len  (period_len)
    );

    pcbg_ctrl #(
        .PHASE_BITS (PHASE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_keep_running (s_tdata[0]),
        .start_inc       (start_inc),
        .inc_step        (inc_step),
        .chirp_count     (chirp_count),
        .period_len      (period_len),
        .out_valid       (item_valid),
        .out_phase       (item_phase),
        .out_flags       (item_flags)
    );

    pcbg_sine #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (item_valid),
        .in_ready   (s_tready),
        .in_phase   (item_phase),
        .in_flags   (item_flags),
        .scale      (scale),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (m_tdata),
        .out_flags  (out_flags)
    );

    assign m_tuser[0] = out_flags.chirp;
    assign m_tlast    = out_flags.last;

endmodule
